// File: rtl/core/tma_pkg.sv
`timescale 1ns / 1ps

package tma_pkg;

	// row layout
	localparam int LANES = 4;
	localparam int SAMPLE_W = 32;

	// window register
	localparam int WINDOW_W = 4;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 4'd2;

	// default largest half width, sets history depth
	localparam int MAX_WINDOW_DEF = 15;

	// quotient bits produced by the serial divider
	localparam int QUOT_BITS = 32;

endpackage

// File: rtl/core/tma_in_if.sv
`timescale 1ns / 1ps

interface tma_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [tma_pkg::SAMPLE_W-1:0]    sample_0;
	logic signed [tma_pkg::SAMPLE_W-1:0]    sample_1;
	logic signed [tma_pkg::SAMPLE_W-1:0]    sample_2;
	logic signed [tma_pkg::SAMPLE_W-1:0]    sample_3;
	logic                                   end_of_series;

	modport source (
		output valid, sample_0, sample_1, sample_2, sample_3, end_of_series,
		input  ready
	);

	modport sink (
		input  valid, sample_0, sample_1, sample_2, sample_3, end_of_series,
		output ready
	);
endinterface

// File: rtl/core/tma_out_if.sv
`timescale 1ns / 1ps

interface tma_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [tma_pkg::SAMPLE_W-1:0]    smooth_0;
	logic signed [tma_pkg::SAMPLE_W-1:0]    smooth_1;
	logic signed [tma_pkg::SAMPLE_W-1:0]    smooth_2;
	logic signed [tma_pkg::SAMPLE_W-1:0]    smooth_3;
	logic                                   final_result;

	modport source (
		output valid, smooth_0, smooth_1, smooth_2, smooth_3, final_result,
		input  ready
	);

	modport sink (
		input  valid, smooth_0, smooth_1, smooth_2, smooth_3, final_result,
		output ready
	);
endinterface

// File: rtl/core/tma_ram.sv
`timescale 1ns / 1ps

module tma_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 4,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/triangular_moving_average_unit.sv
`timescale 1ns / 1ps

// channel   | modport | payload                                  | moves
// ----------+---------+------------------------------------------+----------------------
// rows      | sink    | sample_0..sample_3, end_of_series        | one row word in
// results   | source  | smooth_0..smooth_3, final_result         | one smoothed word out
// window_*  | write   | window_data (4 bit half width)           | register write
//
// a row that gives no result goes through the check and next states only; each result adds
// a multiply-accumulate pass (one tap per cycle from the history ram port), then a
// 32 step serial divide, one divider per lane, all lanes dividing in parallel
// an end of series row gives up to W+1 results one after another in the same sequence
// reset is asynchronous; the history ram is not cleared, a fill count masks
// stale rows, so the block is ready in the first cycle after reset
// a stalled result waits in the output register; the next result of a flush
// waits for it, a new row is taken while it waits

module triangular_moving_average_unit #(
	parameter int MAX_WINDOW = tma_pkg::MAX_WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tma_in_if.sink                        rows,
	tma_out_if.source                     results,
	input  logic                          window_we,
	input  logic [tma_pkg::WINDOW_W-1:0]  window_data
);

	localparam int LANES    = tma_pkg::LANES;
	localparam int SW       = tma_pkg::SAMPLE_W;
	localparam int KW       = tma_pkg::WINDOW_W;
	localparam int QB       = tma_pkg::QUOT_BITS;
	localparam int WREG_MAX = (1 << KW) - 1;
	localparam int WMAX     = (MAX_WINDOW < WREG_MAX) ? MAX_WINDOW : WREG_MAX;
	localparam int HIST     = 2 * WMAX + 1;
	localparam int ADDR_W   = $clog2(HIST);
	localparam int CNT_W    = $clog2(HIST + 1);
	localparam int WGT_W    = $clog2(WMAX + 2);
	localparam int DIV_W    = 2 * WGT_W;
	localparam int ACC_W    = SW + DIV_W;
	localparam int PROD_W   = SW + WGT_W + 1;
	localparam int ROW_W    = LANES * SW;
	localparam int DC_W     = $clog2(QB);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MAC,
		S_DIV,
		S_OUT,
		S_NEXT
	} state_t;

	state_t              state_q;
	logic [KW-1:0]       window_q;
	logic [KW-1:0]       w_q;
	logic [KW-1:0]       k_q;
	logic                end_q;
	logic [ADDR_W-1:0]   wptr_q;
	logic [ADDR_W-1:0]   rptr_q;
	logic [CNT_W-1:0]    rows_seen_q;
	logic [ADDR_W-1:0]   p_q;
	logic [WGT_W-1:0]    weight_q;
	logic                issue_q;
	logic                v1_q;
	logic                v2_q;
	logic [DC_W-1:0]     div_cnt_q;
	logic                out_valid_q;
	logic                final_q;

	// datapath registers
	logic [WGT_W-1:0]        weight_s1;
	logic                    tapok_s1;
	logic signed [ACC_W-1:0] prod_s2 [LANES];
	logic signed [ACC_W-1:0] acc_q [LANES];
	logic [DIV_W-1:0]        divisor_q;
	logic [DIV_W-1:0]        rem_q [LANES];
	logic [QB-1:0]           dq_q [LANES];
	logic                    neg_q [LANES];
	logic [SW-1:0]           smooth_q [LANES];

	logic                accept;
	logic                zpush;
	logic                ram_we;
	logic [ROW_W-1:0]    ram_wdata;
	logic [ROW_W-1:0]    ram_rdata;
	logic [KW-1:0]       w_clamp;
	logic [ADDR_W-1:0]   two_w;
	logic [ADDR_W-1:0]   newest;
	logic [WGT_W-1:0]    wp1;
	logic                mac_done;
	logic                out_load;
	logic                last_step;

	logic signed [PROD_W-1:0] prod_full [LANES];
	logic [ACC_W-1:0]         mag [LANES];
	logic [DIV_W:0]           trial [LANES];
	logic                     ge [LANES];
	logic [DIV_W-1:0]         rem_next [LANES];

	// handshake and control decode
	assign accept    = rows.valid && rows.ready;
	assign rows.ready = (state_q == S_IDLE);
	assign last_step = (k_q == w_q);
	assign zpush     = (state_q == S_NEXT) && end_q && !last_step;
	assign ram_we    = accept || zpush;
	assign ram_wdata = accept ? {rows.sample_3, rows.sample_2, rows.sample_1, rows.sample_0}
	                          : '0;
	assign w_clamp   = (window_q > KW'(WMAX)) ? KW'(WMAX) : window_q;
	assign two_w     = ADDR_W'({w_q, 1'b0});
	assign newest    = (wptr_q == '0) ? ADDR_W'(HIST - 1) : wptr_q - ADDR_W'(1);
	assign wp1       = WGT_W'(w_q) + WGT_W'(1);
	assign mac_done  = (state_q == S_MAC) && !issue_q && !v1_q && !v2_q;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || results.ready);

	// row history, circular with newest at wptr-1
	tma_ram #(
		.WIDTH (ROW_W),
		.DEPTH (HIST)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wptr_q),
		.wdata (ram_wdata),
		.re    (issue_q),
		.raddr (rptr_q),
		.rdata (ram_rdata)
	);

	// per lane multiply, magnitude and divide step
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			prod_full[l] = $signed(ram_rdata[l*SW +: SW]) * $signed({1'b0, weight_s1});
			mag[l]       = acc_q[l][ACC_W-1] ? ACC_W'(-acc_q[l]) : ACC_W'(acc_q[l]);
			trial[l]     = {rem_q[l], dq_q[l][QB-1]};
			ge[l]        = trial[l] >= {1'b0, divisor_q};
			rem_next[l]  = ge[l] ? DIV_W'(trial[l] - {1'b0, divisor_q})
			                     : trial[l][DIV_W-1:0];
		end
	end

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= tma_pkg::WINDOW_RESET;
		end else if (window_we) begin
			window_q <= window_data;
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			w_q         <= '0;
			k_q         <= '0;
			end_q       <= 1'b0;
			wptr_q      <= '0;
			rptr_q      <= '0;
			rows_seen_q <= '0;
			p_q         <= '0;
			weight_q    <= '0;
			issue_q     <= 1'b0;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			if (results.valid && results.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			// history push, real row or flush zero row
			if (ram_we) begin
				wptr_q <= (wptr_q == ADDR_W'(HIST - 1)) ? '0 : wptr_q + ADDR_W'(1);
				if (rows_seen_q != CNT_W'(HIST)) begin
					rows_seen_q <= rows_seen_q + CNT_W'(1);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						end_q   <= rows.end_of_series;
						w_q     <= w_clamp;
						k_q     <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (rows_seen_q > CNT_W'(w_q)) begin
						issue_q  <= 1'b1;
						p_q      <= '0;
						weight_q <= WGT_W'(1);
						rptr_q   <= newest;
						state_q  <= S_MAC;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_MAC: begin
					if (issue_q) begin
						p_q    <= p_q + ADDR_W'(1);
						rptr_q <= (rptr_q == '0) ? ADDR_W'(HIST - 1) : rptr_q - ADDR_W'(1);
						if (p_q < ADDR_W'(w_q)) begin
							weight_q <= weight_q + WGT_W'(1);
						end else begin
							weight_q <= weight_q - WGT_W'(1);
						end
						if (p_q == two_w) begin
							issue_q <= 1'b0;
						end
					end
					v1_q <= issue_q;
					v2_q <= v1_q;
					if (mac_done) begin
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DC_W'(1);
					if (div_cnt_q == DC_W'(QB - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						final_q     <= end_q && last_step;
						state_q     <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (!end_q) begin
						state_q <= S_IDLE;
					end else if (last_step) begin
						// series done: forget the history
						rows_seen_q <= '0;
						wptr_q      <= '0;
						state_q     <= S_IDLE;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= S_CHECK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// multiply-accumulate pipeline, serial divider and output payload
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			divisor_q <= DIV_W'(wp1) * DIV_W'(wp1);
			for (int l = 0; l < LANES; l++) begin
				acc_q[l] <= '0;
			end
		end
		if (issue_q) begin
			weight_s1 <= weight_q;
			tapok_s1  <= CNT_W'(p_q) < rows_seen_q;
		end
		for (int l = 0; l < LANES; l++) begin
			if (v1_q) begin
				prod_s2[l] <= tapok_s1 ? ACC_W'(prod_full[l]) : '0;
			end
			if (v2_q) begin
				acc_q[l] <= acc_q[l] + prod_s2[l];
			end
			if (mac_done) begin
				neg_q[l] <= acc_q[l][ACC_W-1];
				rem_q[l] <= mag[l][ACC_W-1:QB];
				dq_q[l]  <= mag[l][QB-1:0];
			end else if (state_q == S_DIV) begin
				rem_q[l] <= rem_next[l];
				dq_q[l]  <= {dq_q[l][QB-2:0], ge[l]};
			end
			if (out_load) begin
				smooth_q[l] <= neg_q[l] ? SW'(-dq_q[l]) : SW'(dq_q[l]);
			end
		end
	end

	// result port
	assign results.valid        = out_valid_q;
	assign results.final_result = final_q;
	assign results.smooth_0     = smooth_q[0];
	assign results.smooth_1     = smooth_q[1];
	assign results.smooth_2     = smooth_q[2];
	assign results.smooth_3     = smooth_q[3];

endmodule

// File: rtl/core/tma_check.sv
`timescale 1ns / 1ps

module tma_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic final_result
);

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// the last flag of a stalled word does not change
	a_final_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(final_result))
		else $error("final flag changed while stalled");

	// a taken row word keeps the block busy in the next cycle
	a_busy_after_row: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("row word taken in back to back cycles");

	// a fresh result is loaded only while the sequencer is busy
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_ready)
		else $error("result appeared while idle");

endmodule

bind triangular_moving_average_unit tma_check u_tma_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (rows.valid),
	.in_ready     (rows.ready),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.final_result (results.final_result)
);
